[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property, disabled while reset is asserted.
`define MVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Boolean condition that must never hold.
`define MVN_ASSERT_NEVER(lbl, cond, msg) `MVN_ASSERT(lbl, !(cond), msg)
`endif

[hw/rtl/mvn_pkg.sv]
// Shared codes, widths and constants of the vertex normal block.
package mvn_pkg;

  localparam int NRM_W   = 16;  // Q1.14 normal component
  localparam int SUM_W   = 24;  // saturating per-vertex sum
  localparam int SUM_XW  = SUM_W + 1;
  localparam int RAD_W   = 30;  // magnitudes after the range shift
  localparam int Q_BITS  = 14;  // fraction bits of Q1.14
  localparam int QUO_W   = 15;  // quotient bits, result <= 16384

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_VERTEX = 3'd1,
    OP_TRI    = 3'd2,
    OP_CALC   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_DEGEN     = 3'd3,
    ST_NOT_READY = 3'd4
  } status_e;

endpackage

[hw/rtl/mvn_cross.sv]
// Negated cross product (v1-v0)x(v2-v0) on one shared multiplier.
module mvn_cross #(
  parameter int CB = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [3*CB-1:0]       v0_i,
  input  logic [3*CB-1:0]       v1_i,
  input  logic [3*CB-1:0]       v2_i,
  output logic                  done_o,
  output logic signed [2*CB+2:0] cr_x_o,
  output logic signed [2*CB+2:0] cr_y_o,
  output logic signed [2*CB+2:0] cr_z_o
);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [DW-1:0] ux_d, uy_d, uz_d, wx_d, wy_d, wz_d;
  logic signed [DW-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod_q, hold_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [2:0]           cnt_q;
  logic                 run_q, done_q;

  always_comb begin
    ux_d = DW'($signed(v1_i[CB-1:0]))      - DW'($signed(v0_i[CB-1:0]));
    uy_d = DW'($signed(v1_i[2*CB-1:CB]))   - DW'($signed(v0_i[2*CB-1:CB]));
    uz_d = DW'($signed(v1_i[3*CB-1:2*CB])) - DW'($signed(v0_i[3*CB-1:2*CB]));
    wx_d = DW'($signed(v2_i[CB-1:0]))      - DW'($signed(v0_i[CB-1:0]));
    wy_d = DW'($signed(v2_i[2*CB-1:CB]))   - DW'($signed(v0_i[2*CB-1:CB]));
    wz_d = DW'($signed(v2_i[3*CB-1:2*CB])) - DW'($signed(v0_i[3*CB-1:2*CB]));
  end

  // product order: uz*wy, uy*wz, ux*wz, uz*wx, uy*wx, ux*wy
  always_comb begin
    case (cnt_q)
      3'd0: begin opa = uz_q; opb = wy_q; end
      3'd1: begin opa = uy_q; opb = wz_q; end
      3'd2: begin opa = ux_q; opb = wz_q; end
      3'd3: begin opa = uz_q; opb = wx_q; end
      3'd4: begin opa = uy_q; opb = wx_q; end
      default: begin opa = ux_q; opb = wy_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd6) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ux_q <= ux_d; uy_q <= uy_d; uz_q <= uz_d;
      wx_q <= wx_d; wy_q <= wy_d; wz_q <= wz_d;
    end else if (run_q) begin
      if (cnt_q != 3'd6) prod_q <= opa * opb;
      case (cnt_q)
        3'd1, 3'd3, 3'd5: hold_q <= prod_q;
        3'd2: cx_q <= CW'(hold_q) - CW'(prod_q);
        3'd4: cy_q <= CW'(hold_q) - CW'(prod_q);
        3'd6: cz_q <= CW'(hold_q) - CW'(prod_q);
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign cr_x_o = cx_q;
  assign cr_y_o = cy_q;
  assign cr_z_o = cz_q;
endmodule

[hw/rtl/mvn_norm.sv]
// Iterative Q1.14 vector normalizer: range shift, squares, isqrt, division.
module mvn_norm #(
  parameter int W = 35
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [W-1:0]             vec_x_i,
  input  logic signed [W-1:0]             vec_y_i,
  input  logic signed [W-1:0]             vec_z_i,
  output logic                            done_o,
  output logic signed [mvn_pkg::NRM_W-1:0] nrm_x_o,
  output logic signed [mvn_pkg::NRM_W-1:0] nrm_y_o,
  output logic signed [mvn_pkg::NRM_W-1:0] nrm_z_o
);
  import mvn_pkg::*;

  localparam int RW = RAD_W + Q_BITS + 2;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DLD   = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_e;

  nstate_e state_q;
  logic [W-1:0]       m_q [3];
  logic [2:0]         neg_q;
  logic [1:0]         cnt_q, comp_q;
  logic [2*RAD_W-1:0] sq_q;
  logic [63:0]        acc_q, res_q, bit_q;
  logic [RW-1:0]      rem_q;
  logic [QUO_W-2:0]   quo_q;
  logic [3:0]         dstep_q;
  logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
  logic               done_q;

  logic              big;
  logic [RAD_W-1:0]  r0, r1, r2, sq_sel, div_sel;
  logic [63:0]       trial;
  logic              ge_s, ge_d;
  logic [31:0]       len;
  logic [RW-1:0]     dtrial;
  logic [QUO_W-1:0]  qfin;
  logic signed [NRM_W-1:0] qsig;

  always_comb begin
    big = ((m_q[0] >> RAD_W) != '0) || ((m_q[1] >> RAD_W) != '0) ||
          ((m_q[2] >> RAD_W) != '0);
    r0 = RAD_W'(m_q[0]);
    r1 = RAD_W'(m_q[1]);
    r2 = RAD_W'(m_q[2]);
    case (cnt_q)
      2'd0: sq_sel = r0;
      2'd1: sq_sel = r1;
      default: sq_sel = r2;
    endcase
    case (comp_q)
      2'd0: div_sel = r0;
      2'd1: div_sel = r1;
      default: div_sel = r2;
    endcase
    trial  = res_q + bit_q;
    ge_s   = acc_q >= trial;
    len    = res_q[31:0];
    dtrial = RW'(len) << dstep_q;
    ge_d   = rem_q >= dtrial;
    qfin   = {quo_q, ge_d};
    qsig   = neg_q[comp_q] ? -NRM_W'(qfin) : NRM_W'(qfin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            m_q[0] <= vec_x_i[W-1] ? W'(-vec_x_i) : W'(vec_x_i);
            m_q[1] <= vec_y_i[W-1] ? W'(-vec_y_i) : W'(vec_y_i);
            m_q[2] <= vec_z_i[W-1] ? W'(-vec_z_i) : W'(vec_z_i);
            neg_q   <= {vec_z_i[W-1], vec_y_i[W-1], vec_x_i[W-1]};
            state_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (big) begin
            m_q[0] <= m_q[0] >> 1;
            m_q[1] <= m_q[1] >> 1;
            m_q[2] <= m_q[2] >> 1;
          end else begin
            cnt_q   <= '0;
            acc_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_q != 2'd0) acc_q <= acc_q + 64'(sq_q);
          if (cnt_q != 2'd3) sq_q <= sq_sel * sq_sel;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            res_q   <= '0;
            bit_q   <= 64'(1) << 62;
            state_q <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (ge_s) begin
            acc_q <= acc_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            comp_q  <= '0;
            state_q <= N_DLD;
          end
        end
        N_DLD: begin
          if (res_q == '0) begin
            nx_q    <= '0;
            ny_q    <= '0;
            nz_q    <= '0;
            done_q  <= 1'b1;
            state_q <= N_IDLE;
          end else begin
            rem_q   <= RW'({div_sel, {Q_BITS{1'b0}}}) + RW'(len >> 1);
            quo_q   <= '0;
            dstep_q <= 4'(QUO_W - 1);
            state_q <= N_DIV;
          end
        end
        N_DIV: begin
          if (ge_d) rem_q <= rem_q - dtrial;
          quo_q <= qfin[QUO_W-2:0];
          if (dstep_q == '0) begin
            case (comp_q)
              2'd0: nx_q <= qsig;
              2'd1: ny_q <= qsig;
              default: nz_q <= qsig;
            endcase
            if (comp_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= N_DLD;
            end
          end else begin
            dstep_q <= dstep_q - 4'd1;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign nrm_x_o = nx_q;
  assign nrm_y_o = ny_q;
  assign nrm_z_o = nz_q;
endmodule

[hw/rtl/mesh_vertex_normals.sv]
// Top level: mesh stores, command sequencer and compute walk for vertex normals.
//
//  channel   signals                                   direction
//  command   start_i, busy_o, op_i, coord_*_i,         in
//            corner_*_i, vertex_index_i
//  result    done_o, status_o, normal_*_o,             out
//            element_count_o
//  config    cfg_we_i, cfg_wdata_i (invert_winding)    in
//
// A word is taken when start_i is high and busy_o is low. Clear, add and unknown ops
// answer in the next cycle; a read first passes S_READ to take the registered normal memory.
// Compute: clear all sums, then per triangle a cross product and one normalizer pass added
// into its corner sums, then one pass per vertex sum. A pass is a range shift, 32-step
// isqrt and one divide per component. done_o cannot be held off.
// Reset clears totals, the ready flag and invert_winding; stores are not reset.
`include "assert_macros.svh"

module mesh_vertex_normals #(
  parameter int MAX_VERTS  = 1024,
  parameter int MAX_TRIS   = 2048,
  parameter int COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         op_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  input  logic [9:0]         corner_a_i,
  input  logic [9:0]         corner_b_i,
  input  logic [9:0]         corner_c_i,
  input  logic [9:0]         vertex_index_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic [11:0]        element_count_o
);
  import mvn_pkg::*;

  localparam int VIW  = $clog2(MAX_VERTS);
  localparam int TIW  = $clog2(MAX_TRIS);
  localparam int VCW  = $clog2(MAX_VERTS + 1);
  localparam int TCW  = $clog2(MAX_TRIS + 1);
  localparam int CMPW = (VCW > 10) ? VCW : 10;
  localparam int CW   = 2 * COORD_BITS + 3;
  localparam int NW   = (CW > SUM_W) ? CW : SUM_W;
  localparam int CB   = COORD_BITS;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_READ  = 16'h0002,
    S_CLR   = 16'h0004,
    S_TRD   = 16'h0008,
    S_TLAT  = 16'h0010,
    S_VB    = 16'h0020,
    S_VC    = 16'h0040,
    S_VD    = 16'h0080,
    S_XWAIT = 16'h0100,
    S_FWAIT = 16'h0200,
    S_SRD   = 16'h0400,
    S_SWR   = 16'h0800,
    S_NRD   = 16'h1000,
    S_NLAT  = 16'h2000,
    S_NWAIT = 16'h4000,
    S_FIN   = 16'h8000
  } state_e;

  // stores: one write and one registered read per cycle each
  logic [3*CB-1:0]      vert_mem [MAX_VERTS];
  logic [3*VIW-1:0]     tri_mem  [MAX_TRIS];
  logic [3*SUM_W-1:0]   sum_mem  [MAX_VERTS];
  logic [3*NRM_W-1:0]   nrm_mem  [MAX_VERTS];
  logic [3*CB-1:0]      vert_rd_q;
  logic [3*VIW-1:0]     tri_rd_q;
  logic [3*SUM_W-1:0]   sum_rd_q;
  logic [3*NRM_W-1:0]   nrm_rd_q;

  state_e      state_q;
  logic [VCW-1:0] vtot_q, v_q;
  logic [TCW-1:0] ttot_q, t_q;
  logic        ready_q, inv_q, done_q;
  logic [1:0]  j_q;
  logic [3*VIW-1:0] tri_q;
  logic [3*CB-1:0]  v0_q, v1_q;
  status_e     status_q;
  logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
  logic [11:0] count_q;

  logic        accept;
  op_e         op;
  logic [CB-1:0] cx, cy, cz;
  logic        range_bad, degen, tfull, vfull;
  logic [9:0]  c_b_sel, c_c_sel;
  logic [VIW-1:0] corner_j, vert_ra, sum_ra, sum_wa;
  logic        vert_we, tri_we, sum_we, nrm_we;
  logic [3*SUM_W-1:0] sum_wd;
  logic        x_start, x_done, n_start, n_done;
  logic signed [CW-1:0] cr_x, cr_y, cr_z;
  logic signed [NW-1:0] nin_x, nin_y, nin_z;
  logic signed [NRM_W-1:0] nout_x, nout_y, nout_z;

  function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                               input logic signed [NRM_W-1:0] f);
    logic signed [SUM_XW-1:0] t;
    t = SUM_XW'(s) + SUM_XW'(f);
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[SUM_W-1:0];
    end
  endfunction

  // coordinates: truncated to COORD_BITS, wider widths see the raw word zero-extended
  if (CB <= 16) begin : g_coord_narrow
    assign cx = coord_x_i[CB-1:0];
    assign cy = coord_y_i[CB-1:0];
    assign cz = coord_z_i[CB-1:0];
  end else begin : g_coord_wide
    assign cx = CB'($unsigned(coord_x_i));
    assign cy = CB'($unsigned(coord_y_i));
    assign cz = CB'($unsigned(coord_z_i));
  end

  always_comb begin
    accept    = start_i && (state_q == S_IDLE);
    op        = op_e'(op_i);
    range_bad = (CMPW'(corner_a_i) >= CMPW'(vtot_q)) ||
                (CMPW'(corner_b_i) >= CMPW'(vtot_q)) ||
                (CMPW'(corner_c_i) >= CMPW'(vtot_q));
    degen     = (corner_a_i == corner_b_i) || (corner_b_i == corner_c_i) ||
                (corner_c_i == corner_a_i);
    tfull     = ttot_q == TCW'(MAX_TRIS);
    vfull     = vtot_q == VCW'(MAX_VERTS);
    c_b_sel   = inv_q ? corner_c_i : corner_b_i;
    c_c_sel   = inv_q ? corner_b_i : corner_c_i;
    vert_we   = accept && (op == OP_VERTEX) && !vfull;
    tri_we    = accept && (op == OP_TRI) && !range_bad && !degen && !tfull;

    case (j_q)
      2'd0: corner_j = tri_q[VIW-1:0];
      2'd1: corner_j = tri_q[2*VIW-1:VIW];
      default: corner_j = tri_q[3*VIW-1:2*VIW];
    endcase

    case (state_q)
      S_VB: vert_ra = tri_q[2*VIW-1:VIW];
      S_VC: vert_ra = tri_q[3*VIW-1:2*VIW];
      default: vert_ra = tri_rd_q[VIW-1:0];
    endcase

    sum_ra = (state_q == S_SRD) ? corner_j : v_q[VIW-1:0];
    sum_we = (state_q == S_CLR) || (state_q == S_SWR);
    sum_wa = (state_q == S_SWR) ? corner_j : v_q[VIW-1:0];
    if (state_q == S_SWR) begin
      sum_wd = {sat_add($signed(sum_rd_q[3*SUM_W-1:2*SUM_W]), nout_z),
                sat_add($signed(sum_rd_q[2*SUM_W-1:SUM_W]), nout_y),
                sat_add($signed(sum_rd_q[SUM_W-1:0]), nout_x)};
    end else begin
      sum_wd = '0;
    end

    x_start = state_q == S_VD;
    n_start = ((state_q == S_XWAIT) && x_done) || (state_q == S_NLAT);
    if (state_q == S_NLAT) begin
      nin_x = NW'($signed(sum_rd_q[SUM_W-1:0]));
      nin_y = NW'($signed(sum_rd_q[2*SUM_W-1:SUM_W]));
      nin_z = NW'($signed(sum_rd_q[3*SUM_W-1:2*SUM_W]));
    end else begin
      nin_x = NW'(cr_x);
      nin_y = NW'(cr_y);
      nin_z = NW'(cr_z);
    end
    nrm_we = (state_q == S_NWAIT) && n_done;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (vert_we) vert_mem[vtot_q[VIW-1:0]] <= {cz, cy, cx};
    vert_rd_q <= vert_mem[vert_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tri_we) begin
      tri_mem[ttot_q[TIW-1:0]] <= {VIW'(c_c_sel), VIW'(c_b_sel), VIW'(corner_a_i)};
    end
    tri_rd_q <= tri_mem[t_q[TIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nrm_we) nrm_mem[v_q[VIW-1:0]] <= {nout_z, nout_y, nout_x};
    nrm_rd_q <= nrm_mem[VIW'(vertex_index_i)];
  end

  mvn_cross #(.CB(CB)) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(x_start),
    .v0_i   (v0_q),
    .v1_i   (v1_q),
    .v2_i   (vert_rd_q),
    .done_o (x_done),
    .cr_x_o (cr_x),
    .cr_y_o (cr_y),
    .cr_z_o (cr_z)
  );

  mvn_norm #(.W(NW)) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(n_start),
    .vec_x_i(nin_x),
    .vec_y_i(nin_y),
    .vec_z_i(nin_z),
    .done_o (n_done),
    .nrm_x_o(nout_x),
    .nrm_y_o(nout_y),
    .nrm_z_o(nout_z)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vtot_q   <= '0;
      ttot_q   <= '0;
      ready_q  <= 1'b0;
      inv_q    <= 1'b0;
      done_q   <= 1'b0;
      v_q      <= '0;
      t_q      <= '0;
      j_q      <= '0;
      status_q <= ST_OK;
      nx_q     <= '0;
      ny_q     <= '0;
      nz_q     <= '0;
      count_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) inv_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= ST_OK;
            nx_q     <= '0;
            ny_q     <= '0;
            nz_q     <= '0;
            count_q  <= 12'(vtot_q);
            case (op)
              OP_CLEAR: begin
                vtot_q  <= '0;
                ttot_q  <= '0;
                ready_q <= 1'b0;
                count_q <= '0;
                done_q  <= 1'b1;
              end
              OP_VERTEX: begin
                if (vfull) begin
                  status_q <= ST_FULL;
                end else begin
                  vtot_q  <= vtot_q + VCW'(1);
                  count_q <= 12'(vtot_q + VCW'(1));
                  ready_q <= 1'b0;
                end
                done_q <= 1'b1;
              end
              OP_TRI: begin
                count_q <= 12'(ttot_q);
                if (range_bad) begin
                  status_q <= ST_RANGE;
                end else if (degen) begin
                  status_q <= ST_DEGEN;
                end else if (tfull) begin
                  status_q <= ST_FULL;
                end else begin
                  ttot_q  <= ttot_q + TCW'(1);
                  count_q <= 12'(ttot_q + TCW'(1));
                  ready_q <= 1'b0;
                end
                done_q <= 1'b1;
              end
              OP_CALC: begin
                v_q <= '0;
                t_q <= '0;
                state_q <= (vtot_q == '0) ? S_FIN : S_CLR;
              end
              OP_READ: begin
                if (!ready_q) begin
                  status_q <= ST_NOT_READY;
                  done_q   <= 1'b1;
                end else if (CMPW'(vertex_index_i) >= CMPW'(vtot_q)) begin
                  status_q <= ST_RANGE;
                  done_q   <= 1'b1;
                end else begin
                  state_q <= S_READ;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          nx_q    <= $signed(nrm_rd_q[NRM_W-1:0]);
          ny_q    <= $signed(nrm_rd_q[2*NRM_W-1:NRM_W]);
          nz_q    <= $signed(nrm_rd_q[3*NRM_W-1:2*NRM_W]);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_CLR: begin
          if (v_q + VCW'(1) == vtot_q) begin
            v_q     <= '0;
            state_q <= (ttot_q == '0) ? S_NRD : S_TRD;
          end else begin
            v_q <= v_q + VCW'(1);
          end
        end
        S_TRD:  state_q <= S_TLAT;
        S_TLAT: begin
          tri_q   <= tri_rd_q;
          state_q <= S_VB;
        end
        S_VB: begin
          v0_q    <= vert_rd_q;
          state_q <= S_VC;
        end
        S_VC: begin
          v1_q    <= vert_rd_q;
          state_q <= S_VD;
        end
        S_VD:    state_q <= S_XWAIT;
        S_XWAIT: if (x_done) state_q <= S_FWAIT;
        S_FWAIT: begin
          if (n_done) begin
            j_q     <= '0;
            state_q <= S_SRD;
          end
        end
        S_SRD:  state_q <= S_SWR;
        S_SWR: begin
          if (j_q == 2'd2) begin
            if (t_q + TCW'(1) == ttot_q) begin
              v_q     <= '0;
              state_q <= S_NRD;
            end else begin
              t_q     <= t_q + TCW'(1);
              state_q <= S_TRD;
            end
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= S_SRD;
          end
        end
        S_NRD:  state_q <= (v_q == vtot_q) ? S_FIN : S_NLAT;
        S_NLAT: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (n_done) begin
            v_q     <= v_q + VCW'(1);
            state_q <= S_NRD;
          end
        end
        S_FIN: begin
          ready_q  <= 1'b1;
          status_q <= ST_OK;
          nx_q     <= '0;
          ny_q     <= '0;
          nz_q     <= '0;
          count_q  <= 12'(vtot_q);
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = state_q != S_IDLE;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign normal_x_o      = nx_q;
  assign normal_y_o      = ny_q;
  assign normal_z_o      = nz_q;
  assign element_count_o = count_q;

  `MVN_ASSERT(a_vtot_bounded, vtot_q <= VCW'(MAX_VERTS), "vertex total beyond store depth")
  `MVN_ASSERT(a_ttot_bounded, ttot_q <= TCW'(MAX_TRIS), "triangle total beyond store depth")
  `MVN_ASSERT(a_tris_need_verts, (ttot_q == '0) || (vtot_q != '0), "triangles without vertices")
  `MVN_ASSERT(a_accept_answers, (start_i && !busy_o) |=> (done_o || busy_o), "word dropped")
  `MVN_ASSERT_NEVER(a_done_while_busy, done_o && busy_o, "result strobe while busy")
endmodule
